@@ hw/rtl/separate_alpha_pixel_blender_assert.svh @@
// Assertion macros for the separate-alpha pixel blender.
// Users must have clk and rst_n in scope; rst_n is active low.
`ifndef SEPARATE_ALPHA_PIXEL_BLENDER_ASSERT_SVH
`define SEPARATE_ALPHA_PIXEL_BLENDER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SAPB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SAPB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sapb_pkg.sv @@
// Shared types, codes and arithmetic helpers for the separate-alpha pixel blender.
// No dependencies; used by sapb_lane and separate_alpha_pixel_blender.
`default_nettype none

package sapb_pkg;

  localparam int unsigned CHANNEL_BITS   = 8;
  localparam int unsigned PROD_BITS      = 2 * CHANNEL_BITS;
  localparam int unsigned CFG_DATA_BITS  = 2;
  localparam int unsigned CFG_INDEX_BITS = 3;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [PROD_BITS-1:0]    prod_t;

  localparam chan_t CH_MAX     = '1;
  localparam prod_t ROUND_BIAS = PROD_BITS'(((2 ** CHANNEL_BITS) - 1) / 2);

  typedef enum logic [CFG_DATA_BITS-1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_RSUB = 2'd2
  } blend_op_t;

  typedef enum logic [CFG_DATA_BITS-1:0] {
    FACTOR_ZERO      = 2'd0,
    FACTOR_ONE       = 2'd1,
    FACTOR_ALPHA     = 2'd2,
    FACTOR_INV_ALPHA = 2'd3
  } blend_factor_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_COLOR_OP         = 3'd0,
    REG_COLOR_SRC_FACTOR = 3'd1,
    REG_COLOR_DST_FACTOR = 3'd2,
    REG_ALPHA_OP         = 3'd3,
    REG_ALPHA_SRC_FACTOR = 3'd4,
    REG_ALPHA_DST_FACTOR = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    chan_t src_red;
    chan_t src_green;
    chan_t src_blue;
    chan_t src_alpha;
    chan_t dst_red;
    chan_t dst_green;
    chan_t dst_blue;
    chan_t dst_alpha;
  } sapb_in_t;

  typedef struct packed {
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    chan_t out_alpha;
  } sapb_out_t;

  // Per-stage load strobes for the lane datapath.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } sapb_adv_t;

  function automatic chan_t factor_value(input blend_factor_t code, input chan_t alpha);
    chan_t f;
    case (code)
      FACTOR_ZERO:      f = '0;
      FACTOR_ONE:       f = CH_MAX;
      FACTOR_ALPHA:     f = alpha;
      FACTOR_INV_ALPHA: f = CH_MAX - alpha;
      default:          f = '0;
    endcase
    return f;
  endfunction

  // v / M with M = 2^N - 1: split v = a*2^N + b, so v = a*M + (a + b),
  // and a + b never exceeds 2M.
  function automatic chan_t div_by_max(input prod_t v);
    logic [CHANNEL_BITS:0] hi;
    logic [CHANNEL_BITS:0] lo;
    logic [CHANNEL_BITS:0] sum;
    logic [CHANNEL_BITS:0] q;
    hi  = {1'b0, v[PROD_BITS-1:CHANNEL_BITS]};
    lo  = {1'b0, v[CHANNEL_BITS-1:0]};
    sum = hi + lo;
    q   = hi;
    if (sum >= {1'b0, CH_MAX}) begin
      q = q + 1'b1;
    end
    if (sum >= {CH_MAX, 1'b0}) begin
      q = q + 1'b1;
    end
    return q[CHANNEL_BITS-1:0];
  endfunction

  function automatic chan_t combine(input blend_op_t op, input chan_t s, input chan_t d);
    logic [CHANNEL_BITS:0] total;
    chan_t r;
    total = {1'b0, s} + {1'b0, d};
    case (op)
      OP_SUB:  r = (s > d) ? s - d : '0;
      OP_RSUB: r = (d > s) ? d - s : '0;
      default: r = total[CHANNEL_BITS] ? CH_MAX : total[CHANNEL_BITS-1:0];
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sapb_lane.sv @@
// One channel of the blend datapath: multiply, scale by 1/M, combine.
// Depends on sapb_pkg; stage strobes come from the top-level pipeline control.
`default_nettype none

module sapb_lane (
  input  wire logic                  clk,
  input  wire sapb_pkg::sapb_adv_t   adv,
  input  wire sapb_pkg::blend_op_t   op,
  input  wire sapb_pkg::chan_t       src_chan,
  input  wire sapb_pkg::chan_t       dst_chan,
  input  wire sapb_pkg::chan_t       src_fac,
  input  wire sapb_pkg::chan_t       dst_fac,
  output sapb_pkg::chan_t            result
);

  sapb_pkg::prod_t src_prod_r;
  sapb_pkg::prod_t dst_prod_r;
  sapb_pkg::chan_t src_scaled_r;
  sapb_pkg::chan_t dst_scaled_r;
  sapb_pkg::chan_t result_r;

  // Stage 2: product plus rounding bias
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      src_prod_r <= {{sapb_pkg::CHANNEL_BITS{1'b0}}, src_chan} *
                    {{sapb_pkg::CHANNEL_BITS{1'b0}}, src_fac} + sapb_pkg::ROUND_BIAS;
      dst_prod_r <= {{sapb_pkg::CHANNEL_BITS{1'b0}}, dst_chan} *
                    {{sapb_pkg::CHANNEL_BITS{1'b0}}, dst_fac} + sapb_pkg::ROUND_BIAS;
    end
  end

  // Stage 3: divide by full scale
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      src_scaled_r <= sapb_pkg::div_by_max(src_prod_r);
      dst_scaled_r <= sapb_pkg::div_by_max(dst_prod_r);
    end
  end

  // Stage 4: saturating add or clamped subtract
  always_ff @(posedge clk) begin
    if (adv.s4) begin
      result_r <= sapb_pkg::combine(op, src_scaled_r, dst_scaled_r);
    end
  end

  assign result = result_r;

endmodule

`default_nettype wire

@@ hw/rtl/separate_alpha_pixel_blender.sv @@
// Separate-alpha pixel blender: top level with input stage, pipeline control and
// configuration registers. Depends on sapb_pkg, sapb_lane and the assertion header.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one source and one
//   destination RGBA pixel per transaction; the result channel
//   (out_valid/out_ready/out_data) returns one blended RGBA pixel per input,
//   in order.
//   An accepted pixel passes four registered stages (factor select,
//   multiply, scale by 1/M, combine) before out_valid rises. Throughput:
//   one pixel per clock while out_ready stays high, since every stage can
//   load in the cycle its item moves on.
//   Each stage holds its item while the stage after it is full and stalled,
//   so a low out_ready fills empty stages first and drops in_ready only once
//   all four stages are occupied. Nothing is lost or duplicated.
//   Reset (rst_n low at a clock edge) empties the pipeline and loads the
//   blend registers with colour and alpha set to add, source factor one,
//   destination factor inverse source alpha.
//   cfg_wr_en writes cfg_data into register cfg_index; indexes
//   beyond the six registers are ignored. Write only while the block is idle.
`default_nettype none

`include "separate_alpha_pixel_blender_assert.svh"

module separate_alpha_pixel_blender (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire sapb_pkg::sapb_in_t                      in_data,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output sapb_pkg::sapb_out_t                          out_data,
  input  wire logic                                    cfg_wr_en,
  input  wire logic [sapb_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [sapb_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  sapb_pkg::blend_op_t     color_op_r;
  sapb_pkg::blend_factor_t color_src_factor_r;
  sapb_pkg::blend_factor_t color_dst_factor_r;
  sapb_pkg::blend_op_t     alpha_op_r;
  sapb_pkg::blend_factor_t alpha_src_factor_r;
  sapb_pkg::blend_factor_t alpha_dst_factor_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  sapb_pkg::sapb_adv_t adv;

  sapb_pkg::sapb_in_t pix_r;
  sapb_pkg::chan_t    color_sf_r;
  sapb_pkg::chan_t    color_df_r;
  sapb_pkg::chan_t    alpha_sf_r;
  sapb_pkg::chan_t    alpha_df_r;

  sapb_pkg::chan_t red_res, green_res, blue_res, alpha_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_op_r         <= sapb_pkg::OP_ADD;
      color_src_factor_r <= sapb_pkg::FACTOR_ONE;
      color_dst_factor_r <= sapb_pkg::FACTOR_INV_ALPHA;
      alpha_op_r         <= sapb_pkg::OP_ADD;
      alpha_src_factor_r <= sapb_pkg::FACTOR_ONE;
      alpha_dst_factor_r <= sapb_pkg::FACTOR_INV_ALPHA;
    end else if (cfg_wr_en) begin
      case (sapb_pkg::cfg_reg_t'(cfg_index))
        sapb_pkg::REG_COLOR_OP:         color_op_r <= sapb_pkg::blend_op_t'(cfg_data);
        sapb_pkg::REG_COLOR_SRC_FACTOR: color_src_factor_r <= sapb_pkg::blend_factor_t'(cfg_data);
        sapb_pkg::REG_COLOR_DST_FACTOR: color_dst_factor_r <= sapb_pkg::blend_factor_t'(cfg_data);
        sapb_pkg::REG_ALPHA_OP:         alpha_op_r <= sapb_pkg::blend_op_t'(cfg_data);
        sapb_pkg::REG_ALPHA_SRC_FACTOR: alpha_src_factor_r <= sapb_pkg::blend_factor_t'(cfg_data);
        sapb_pkg::REG_ALPHA_DST_FACTOR: alpha_dst_factor_r <= sapb_pkg::blend_factor_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its item moves on this cycle
  always_comb begin
    rdy4   = !v4_r || out_ready;
    rdy3   = !v3_r || rdy4;
    rdy2   = !v2_r || rdy3;
    rdy1   = !v1_r || rdy2;
    adv.s2 = rdy2 && v1_r;
    adv.s3 = rdy3 && v2_r;
    adv.s4 = rdy4 && v3_r;
  end

  assign in_ready  = rdy1;
  assign out_valid = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Stage 1: hold the pixel pair and resolve the factors from source alpha
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      pix_r      <= in_data;
      color_sf_r <= sapb_pkg::factor_value(color_src_factor_r, in_data.src_alpha);
      color_df_r <= sapb_pkg::factor_value(color_dst_factor_r, in_data.src_alpha);
      alpha_sf_r <= sapb_pkg::factor_value(alpha_src_factor_r, in_data.src_alpha);
      alpha_df_r <= sapb_pkg::factor_value(alpha_dst_factor_r, in_data.src_alpha);
    end
  end

  sapb_lane u_lane_red (
    .clk      (clk),
    .adv      (adv),
    .op       (color_op_r),
    .src_chan (pix_r.src_red),
    .dst_chan (pix_r.dst_red),
    .src_fac  (color_sf_r),
    .dst_fac  (color_df_r),
    .result   (red_res)
  );

  sapb_lane u_lane_green (
    .clk      (clk),
    .adv      (adv),
    .op       (color_op_r),
    .src_chan (pix_r.src_green),
    .dst_chan (pix_r.dst_green),
    .src_fac  (color_sf_r),
    .dst_fac  (color_df_r),
    .result   (green_res)
  );

  sapb_lane u_lane_blue (
    .clk      (clk),
    .adv      (adv),
    .op       (color_op_r),
    .src_chan (pix_r.src_blue),
    .dst_chan (pix_r.dst_blue),
    .src_fac  (color_sf_r),
    .dst_fac  (color_df_r),
    .result   (blue_res)
  );

  sapb_lane u_lane_alpha (
    .clk      (clk),
    .adv      (adv),
    .op       (alpha_op_r),
    .src_chan (pix_r.src_alpha),
    .dst_chan (pix_r.dst_alpha),
    .src_fac  (alpha_sf_r),
    .dst_fac  (alpha_df_r),
    .result   (alpha_res)
  );

  always_comb begin
    out_data.out_red   = red_res;
    out_data.out_green = green_res;
    out_data.out_blue  = blue_res;
    out_data.out_alpha = alpha_res;
  end

  `SAPB_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, v1_r, "accepted transaction not in stage 1")
  `SAPB_ASSERT_NEXT(a_stall_keeps, v3_r && v4_r && !out_ready, v3_r && v4_r, "stall lost an item")
  `SAPB_ASSERT_NOW(a_full_blocks, v1_r && v2_r && v3_r && v4_r && !out_ready, !in_ready, "taken when full")
  `SAPB_ASSERT_NEXT(a_drain, v3_r && (!v4_r || out_ready), v4_r, "stage 3 item did not reach the output")

endmodule

`default_nettype wire
